// ===== src/uri_component_tagger_assert.svh =====
// assertion macros for the uri component tagger
`ifndef URI_COMPONENT_TAGGER_ASSERT_SVH
`define URI_COMPONENT_TAGGER_ASSERT_SVH

// implication checked one edge at a time, held off during reset
`define UCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uri component tagger: check failed");

// consequence checked on the edge after the antecedent
`define UCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uri component tagger: sequence check failed");

`endif

// ===== src/uct_pkg.sv =====
// shared types, codes and character classes for the uri component tagger
package uct_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_uri;
  } uct_in_t;

  typedef struct packed {
    logic [3:0]  byte_tag;
    logic [1:0]  status;
    logic [2:0]  resolve_code;
    logic [15:0] port_value;
    logic        port_present;
  } uct_out_t;

  localparam logic [3:0] TAG_DELIM     = 4'd0;
  localparam logic [3:0] TAG_FIRST_PND = 4'd1;
  localparam logic [3:0] TAG_AUTH_PND  = 4'd2;
  localparam logic [3:0] TAG_USERINFO  = 4'd3;
  localparam logic [3:0] TAG_HOST      = 4'd4;
  localparam logic [3:0] TAG_PORT      = 4'd5;
  localparam logic [3:0] TAG_PATH      = 4'd6;
  localparam logic [3:0] TAG_QUERY     = 4'd7;
  localparam logic [3:0] TAG_FRAGMENT  = 4'd8;

  localparam logic [1:0] ST_CONT = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_REJ  = 2'd2;

  localparam logic [2:0] RES_NONE       = 3'd0;
  localparam logic [2:0] RES_FIRST_SCH  = 3'd1;
  localparam logic [2:0] RES_FIRST_HOST = 3'd2;
  localparam logic [2:0] RES_AUTH_USER  = 3'd3;
  localparam logic [2:0] RES_AUTH_HOST  = 3'd4;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_valid(input logic [7:0] c);
    logic alpha;
    logic punct;
    alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    case (c)
      8'h2d, 8'h5f, 8'h2e, CH_TILDE, 8'h21, 8'h2a, 8'h27, 8'h28, 8'h29, 8'h3b,
      CH_COLON, CH_AT, 8'h26, 8'h3d, 8'h2b, 8'h24, 8'h2c, CH_SLASH, CH_QUEST,
      CH_HASH, 8'h5b, 8'h5d, CH_PCT: punct = 1'b1;
      default: punct = 1'b0;
    endcase
    return alpha || is_digit(c) || punct;
  endfunction

  function automatic logic ends_authority(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_QUEST) || (c == CH_HASH);
  endfunction

endpackage

// ===== src/uct_in_stage.sv =====
// input register stage with stall back-pressure
module uct_in_stage import uct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  uct_in_t in_data,
  input  logic    adv,
  output logic    s1_valid,
  output uct_in_t s1_data
);

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  uct_in_t s1_data_r;
  logic    take;

  assign in_stall     = s1_valid_r && !adv;
  assign take         = in_valid && !in_stall;
  assign s1_valid_nxt = take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (take) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

// ===== src/uct_core.sv =====
// parse state, per-byte tagging logic and result register
module uct_core import uct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s1_valid,
  input  uct_in_t  s1_data,
  output logic     adv,
  output logic     out_valid,
  input  logic     out_stall,
  output uct_out_t out_data
);

  typedef enum logic [3:0] {
    PH_FIRST, PH_COLON, PH_SLASH1, PH_AUTH_START, PH_AUTH, PH_AUTH_BAD,
    PH_HOST_START, PH_HOST, PH_PORT, PH_PATH, PH_QUERY, PH_FRAG, PH_DRAIN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic        colon_r, colon_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic        pseen_r, pseen_nxt;
  logic        pdc_r, pdc_nxt;
  logic        out_valid_r, out_valid_nxt;
  uct_out_t    out_data_r;
  uct_out_t    res_d;

  logic [7:0]  c;
  logic        dig;
  logic [19:0] acc10;
  logic        ovf;
  logic        rej;
  logic        pseen_end;
  logic        upd;

  assign c     = s1_data.char_byte;
  assign dig   = is_digit(c);
  assign acc10 = {4'b0, accum_r} * 20'd10 + {16'b0, c[3:0]};
  assign ovf   = acc10[19:16] != 4'd0;

  always_comb begin
    phase_nxt    = phase_r;
    accum_nxt    = accum_r;
    colon_nxt    = colon_r;
    nonempty_nxt = nonempty_r;
    pseen_nxt    = pseen_r;
    pdc_nxt      = pdc_r;
    res_d        = '{byte_tag: TAG_DELIM, status: ST_CONT, resolve_code: RES_NONE,
                     port_value: 16'd0, port_present: 1'b0};
    rej          = 1'b0;
    pseen_end    = pseen_r;
    if (s1_data.end_of_uri) begin
      unique case (phase_r)
        PH_FIRST: begin
          if (nonempty_r) begin
            res_d.status       = ST_ACC;
            res_d.resolve_code = RES_FIRST_HOST;
          end else begin
            res_d.status = ST_REJ;
          end
        end
        PH_AUTH: begin
          if (!colon_r) begin
            res_d.status       = ST_ACC;
            res_d.resolve_code = RES_AUTH_HOST;
          end else if (pdc_r) begin
            res_d.status       = ST_ACC;
            res_d.resolve_code = RES_AUTH_HOST;
            pseen_end          = 1'b1;
          end else begin
            res_d.status = ST_REJ;
          end
        end
        PH_HOST, PH_PATH, PH_QUERY, PH_FRAG: res_d.status = ST_ACC;
        PH_PORT: res_d.status = pdc_r ? ST_ACC : ST_REJ;
        PH_DRAIN: res_d.status = ST_CONT;
        default: res_d.status = ST_REJ;
      endcase
      if (res_d.status == ST_ACC && pseen_end) begin
        res_d.port_value   = accum_r;
        res_d.port_present = 1'b1;
      end
      phase_nxt    = PH_FIRST;
      accum_nxt    = 16'd0;
      colon_nxt    = 1'b0;
      nonempty_nxt = 1'b0;
      pseen_nxt    = 1'b0;
      pdc_nxt      = 1'b0;
    end else begin
      unique case (phase_r)
        PH_FIRST: begin
          if (c == CH_COLON) begin
            if (!nonempty_r) rej = 1'b1;
            else phase_nxt = PH_COLON;
          end else if (c == CH_SLASH) begin
            res_d.resolve_code = nonempty_r ? RES_FIRST_HOST : RES_NONE;
            res_d.byte_tag     = TAG_PATH;
            phase_nxt          = PH_PATH;
          end else if (is_valid(c) && c != CH_QUEST && c != CH_HASH) begin
            res_d.byte_tag = TAG_FIRST_PND;
            nonempty_nxt   = 1'b1;
          end else begin
            rej = 1'b1;
          end
        end
        PH_COLON: begin
          if (dig) begin
            res_d.resolve_code = RES_FIRST_HOST;
            res_d.byte_tag     = TAG_PORT;
            pseen_nxt          = 1'b1;
            accum_nxt          = acc10[15:0];
            pdc_nxt            = 1'b1;
            phase_nxt          = PH_PORT;
          end else if (c == CH_SLASH) begin
            res_d.resolve_code = RES_FIRST_SCH;
            phase_nxt          = PH_SLASH1;
          end else if (c == CH_QUEST) begin
            res_d.resolve_code = RES_FIRST_SCH;
            phase_nxt          = PH_QUERY;
          end else if (c == CH_HASH) begin
            res_d.resolve_code = RES_FIRST_SCH;
            phase_nxt          = PH_FRAG;
          end else begin
            rej = 1'b1;
          end
        end
        PH_SLASH1: begin
          if (c == CH_SLASH) phase_nxt = PH_AUTH_START;
          else rej = 1'b1;
        end
        PH_AUTH_START: begin
          if (c == CH_SLASH) begin
            res_d.byte_tag = TAG_PATH;
            phase_nxt      = PH_PATH;
          end else if (!is_valid(c) || c == CH_AT || c == CH_QUEST || c == CH_HASH) begin
            rej = 1'b1;
          end else begin
            res_d.byte_tag = TAG_AUTH_PND;
            nonempty_nxt   = 1'b1;
            phase_nxt      = PH_AUTH;
            if (c == CH_COLON) colon_nxt = 1'b1;
          end
        end
        PH_AUTH, PH_AUTH_BAD: begin
          if (c == CH_AT) begin
            res_d.resolve_code = RES_AUTH_USER;
            colon_nxt          = 1'b0;
            accum_nxt          = 16'd0;
            pdc_nxt            = 1'b0;
            nonempty_nxt       = 1'b0;
            phase_nxt          = PH_HOST_START;
          end else if (ends_authority(c)) begin
            if (colon_r && (phase_r == PH_AUTH_BAD || !pdc_r)) begin
              rej = 1'b1;
            end else begin
              res_d.resolve_code = RES_AUTH_HOST;
              if (colon_r) pseen_nxt = 1'b1;
              if (c == CH_SLASH) begin
                res_d.byte_tag = TAG_PATH;
                phase_nxt      = PH_PATH;
              end else begin
                phase_nxt = (c == CH_QUEST) ? PH_QUERY : PH_FRAG;
              end
            end
          end else if (is_valid(c)) begin
            res_d.byte_tag = TAG_AUTH_PND;
            if (phase_r == PH_AUTH) begin
              if (colon_r) begin
                if (!dig || ovf) begin
                  phase_nxt = PH_AUTH_BAD;
                end else begin
                  accum_nxt = acc10[15:0];
                  pdc_nxt   = 1'b1;
                end
              end else if (c == CH_COLON) begin
                colon_nxt = 1'b1;
              end
            end
          end else begin
            rej = 1'b1;
          end
        end
        PH_HOST_START: begin
          if (is_valid(c) && c != CH_COLON && c != CH_AT && !ends_authority(c)) begin
            res_d.byte_tag = TAG_HOST;
            nonempty_nxt   = 1'b1;
            phase_nxt      = PH_HOST;
          end else begin
            rej = 1'b1;
          end
        end
        PH_HOST: begin
          if (c == CH_COLON) begin
            pseen_nxt = 1'b1;
            pdc_nxt   = 1'b0;
            phase_nxt = PH_PORT;
          end else if (ends_authority(c)) begin
            if (c == CH_SLASH) begin
              res_d.byte_tag = TAG_PATH;
              phase_nxt      = PH_PATH;
            end else begin
              phase_nxt = (c == CH_QUEST) ? PH_QUERY : PH_FRAG;
            end
          end else if (is_valid(c) && c != CH_AT) begin
            res_d.byte_tag = TAG_HOST;
          end else begin
            rej = 1'b1;
          end
        end
        PH_PORT: begin
          if (dig) begin
            res_d.byte_tag = TAG_PORT;
            if (ovf) begin
              rej = 1'b1;
            end else begin
              accum_nxt = acc10[15:0];
              pdc_nxt   = 1'b1;
            end
          end else if (ends_authority(c) && pdc_r) begin
            if (c == CH_SLASH) begin
              res_d.byte_tag = TAG_PATH;
              phase_nxt      = PH_PATH;
            end else begin
              phase_nxt = (c == CH_QUEST) ? PH_QUERY : PH_FRAG;
            end
          end else begin
            rej = 1'b1;
          end
        end
        PH_PATH: begin
          if (c == CH_QUEST) phase_nxt = PH_QUERY;
          else if (c == CH_HASH) phase_nxt = PH_FRAG;
          else if (is_valid(c)) res_d.byte_tag = TAG_PATH;
          else rej = 1'b1;
        end
        PH_QUERY: begin
          if (c == CH_HASH) phase_nxt = PH_FRAG;
          else if (is_valid(c)) res_d.byte_tag = TAG_QUERY;
          else rej = 1'b1;
        end
        PH_FRAG: begin
          if (is_valid(c) && c != CH_HASH) res_d.byte_tag = TAG_FRAGMENT;
          else rej = 1'b1;
        end
        default: phase_nxt = PH_DRAIN;
      endcase
      if (rej) begin
        res_d.byte_tag     = TAG_DELIM;
        res_d.resolve_code = RES_NONE;
        res_d.status       = ST_REJ;
        phase_nxt          = PH_DRAIN;
        accum_nxt          = 16'd0;
        colon_nxt          = 1'b0;
        nonempty_nxt       = 1'b0;
        pseen_nxt          = 1'b0;
        pdc_nxt            = 1'b0;
      end
    end
  end

  assign adv           = !out_valid_r || !out_stall;
  assign upd           = adv && s1_valid;
  assign out_valid_nxt = adv ? s1_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      accum_r     <= 16'd0;
      colon_r     <= 1'b0;
      nonempty_r  <= 1'b0;
      pseen_r     <= 1'b0;
      pdc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (upd) begin
        phase_r    <= phase_nxt;
        accum_r    <= accum_nxt;
        colon_r    <= colon_nxt;
        nonempty_r <= nonempty_nxt;
        pseen_r    <= pseen_nxt;
        pdc_r      <= pdc_nxt;
      end
    end
    if (upd) begin
      out_data_r <= res_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/uri_component_tagger.sv =====
// top level of the uri component tagger
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid, in_stall | uct_in_t  (char_byte, end_of_uri)
//  out_    | output    | out_valid, out_stall | uct_out_t (tag, status, resolve, port)
//
// one transaction in, one transaction out; a new byte is taken every cycle while in_stall is low
// a byte passes through the input register, then the tagging logic into the result register
// the phase/port state loop closes inside the core, setting the one-byte-per-cycle rate
// synchronous active-low reset returns the parser to the first-token phase
// a stalled result holds; the input register keeps taking bytes until both stages are full
`include "uri_component_tagger_assert.svh"

module uri_component_tagger import uct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  uct_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output uct_out_t out_data
);

  logic    adv;
  logic    s1_valid;
  uct_in_t s1_data;
  logic    out_rej;
  logic    rej_clean;
  logic    port_shown;
  logic    port_hidden;
  logic    core_take;

  uct_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  uct_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_rej     = out_valid && (out_data.status == ST_REJ);
  assign rej_clean   = (out_data.byte_tag == TAG_DELIM) && (out_data.resolve_code == RES_NONE);
  assign port_shown  = out_valid && out_data.port_present;
  assign port_hidden = out_valid && !out_data.port_present;
  assign core_take   = s1_valid && adv;

  `UCT_ASSERT_IMP(a_rej_clean, clk, rst_n, out_rej, rej_clean)
  `UCT_ASSERT_IMP(a_port_on_acc, clk, rst_n, port_shown, out_data.status == ST_ACC)
  `UCT_ASSERT_IMP(a_no_port_zero, clk, rst_n, port_hidden, out_data.port_value == 16'd0)
  `UCT_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  `UCT_ASSERT_NEXT(a_full_take, clk, rst_n, core_take, out_valid)

endmodule
